[hw/rtl/assert_macros.svh]
// assertion macros for the ladder lowpass rtl
// no dependencies; empty bodies when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[hw/rtl/llf_pkg.sv]
// shared constants and types for the ladder lowpass filter
// no dependencies
package llf_pkg;
  localparam int LOG_BLOCK = 6;
  localparam int IDX_W = (LOG_BLOCK < 1) ? 1 : LOG_BLOCK;
  localparam logic [31:0] Q24_ONE = 32'h0100_0000;
  localparam logic [63:0] LOOP_LIMIT = 64'h0001_0000_0100_0000;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_START = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_RAMP  = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_ADD   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;
endpackage

[hw/rtl/llf_mul.sv]
// bit-serial signed 32x32 multiplier, two multiplier bits per cycle
// uses llf_pkg; result is (a*b)>>>24 truncated to 32 bits
module llf_mul import llf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [31:0] prod
);
  logic [63:0] acc;
  logic [63:0] mcand;
  logic [31:0] mplier;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] pp0, pp1;

  assign pp0 = mplier[0] ? mcand : 64'd0;
  assign pp1 = mplier[1] ? (cnt == 5'd15 ? -(mcand << 1) : (mcand << 1)) : 64'd0;
  assign prod = acc[55:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'd0;
        acc <= 64'd0;
        mcand <= {{32{a[31]}}, a};
        mplier <= b;
      end else if (busy) begin
        acc <= acc + pp0 + pp1;
        mcand <= mcand << 2;
        mplier <= mplier >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[hw/rtl/ladder_lowpass_filter_core.sv]
// channel  | valid         | stall         | payload
// input    | in_valid      | in_stall      | sample_in cutoff_coeff resonance
// output   | out_valid     | out_stall     | filtered
// one sample is taken at a time, from accept to the next accept: five products on one shared
// two-bit-per-cycle multiplier; a block start adds the loop gain product, and the restoring
// divider when the loop gain limit applies
// reset clears the state machine, stages, ramps and block index; the input is free while a result
// waits, a new result holds until the stalled one is taken
// top level of the ladder lowpass; uses llf_pkg, llf_mul, assert_macros.svh
`include "assert_macros.svh"
module ladder_lowpass_filter_core import llf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] sample_in,
  input  logic        [30:0] cutoff_coeff,
  input  logic signed [31:0] resonance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] filtered
);
  state_t state;
  logic [31:0] x [4];
  logic [31:0] coeff_now, gain_now, coeff_step, gain_step;
  logic [31:0] prev_coeff, prev_gain, sig, cut, res, k0, a0;
  logic [IDX_W-1:0] sample_index;
  logic [2:0] phase;
  logic [1:0] pidx, pnext;
  logic [31:0] rem, quo;
  logic [31:0] num;
  logic [5:0] dcnt;
  logic mstart, mdone;
  logic [31:0] ma, mb, prod;
  logic [32:0] trial;
  logic [31:0] a1;

  llf_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod);

  assign in_stall = (state != ST_IDLE);
  assign trial = {rem, num[31]} - {1'b0, a0};
  assign a1 = (cut < Q24_ONE) ? cut : Q24_ONE;
  assign pidx = phase[1:0] - 2'd1;
  assign pnext = phase[1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      mstart <= 1'b0;
      for (int i = 0; i < 4; i++) x[i] <= 32'd0;
      coeff_now <= 32'd0; gain_now <= 32'd0;
      coeff_step <= 32'd0; gain_step <= 32'd0;
      prev_coeff <= 32'd0; prev_gain <= 32'd0;
      sample_index <= '0;
    end else begin
      mstart <= (state == ST_RAMP) || (state == ST_START && dcnt == 6'd0) ||
                (state == ST_ADD && phase != 3'd4);
      if (out_valid && !out_stall && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            sig <= sample_in;
            cut <= {1'b0, cutoff_coeff};
            res <= resonance;
            a0 <= (prev_coeff < Q24_ONE) ? prev_coeff : Q24_ONE;
            k0 <= prev_gain;
            if (sample_index == '0 || LOG_BLOCK == 0) begin
              state <= ST_START;
              dcnt <= 6'd0;
            end else state <= ST_RAMP;
          end
        end
        ST_START: begin
          if (dcnt == 6'd0) begin
            coeff_step <= 32'($signed(a1 - a0) >>> LOG_BLOCK);
            gain_step <= 32'($signed(res - k0) >>> LOG_BLOCK);
            ma <= a0; mb <= k0;
            dcnt <= 6'd1;
          end else if (mdone) begin
            if (a0 != 32'd0 && $signed(prod) > $signed(Q24_ONE)) begin
              rem <= 32'd0; num <= 32'h4000_0000; quo <= 32'd0;
              dcnt <= 6'd0;
              state <= ST_DIV;
            end else begin
              coeff_now <= a0; gain_now <= k0;
              state <= ST_RAMP;
            end
            prev_coeff <= cut; prev_gain <= res;
          end
        end
        ST_DIV: begin
          if (!trial[32]) begin
            rem <= trial[31:0]; quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], num[31]}; quo <= {quo[30:0], 1'b0};
          end
          num <= num << 1;
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd31) begin
            coeff_now <= a0;
            gain_now <= {quo[12:0], ~trial[32], 18'd0};
            state <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          coeff_now <= coeff_now + coeff_step;
          gain_now <= gain_now + gain_step;
          ma <= gain_now + gain_step; mb <= x[3];
          phase <= 3'd0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mdone) state <= ST_ADD;
        end
        ST_ADD: begin
          if (phase == 3'd0) begin
            ma <= sig - prod - x[0];
          end else begin
            x[pidx] <= x[pidx] + prod;
            if (phase != 3'd4) ma <= x[pidx] + prod - x[pnext];
          end
          mb <= coeff_now;
          if (phase == 3'd4) state <= ST_OUT;
          else begin
            phase <= phase + 3'd1;
            state <= ST_MUL;
          end
        end
        ST_OUT: begin
          if (!(out_valid && out_stall)) begin
            out_valid <= 1'b1;
            filtered <= x[3];
            sample_index <= (LOG_BLOCK == 0) ? '0 : sample_index + 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(filtered))
  `ASSERT_IMPLIES(a_busy_stall, clk, rst, state != ST_IDLE, in_stall)
  `ASSERT_NEXT(a_mul_done, clk, rst, state == ST_MUL && mdone, state == ST_ADD)
endmodule

[bench/ladder_lowpass_filter_core_tb.sv]
// testbench for ladder_lowpass_filter_core: four-pole ladder lowpass in q24
// drives random and directed samples, predicts each output, checks in order
// depends on llf_pkg and the core rtl
`timescale 1ns / 1ps
module ladder_lowpass_filter_core_tb import llf_pkg::*;;

  logic clk, rst;
  logic in_valid, in_stall;
  logic signed [31:0] sample_in;
  logic [30:0] cutoff_coeff;
  logic signed [31:0] resonance;
  logic out_valid, out_stall;
  logic signed [31:0] filtered;

  ladder_lowpass_filter_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_in(sample_in), .cutoff_coeff(cutoff_coeff), .resonance(resonance),
    .out_valid(out_valid), .out_stall(out_stall), .filtered(filtered)
  );

  localparam int WATCHDOG = 20000;

  // filter state
  logic [31:0] stage_v [4];
  logic [31:0] coeff_cur, gain_cur, coeff_inc, gain_inc, last_coeff, last_gain;
  logic [LOG_BLOCK-1:0] pos_in_block;

  logic [31:0] filtered_q [$];
  int errors = 0;
  int beats_in = 0, beats_out = 0;
  int idle_cnt = 0;
  bit calm = 0;
  bit sink_idle_en = 1;

  function automatic logic [31:0] q24_mul(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return 32'(p >>> 24);
  endfunction

  function automatic logic [31:0] ladder_predict(logic [31:0] sig, logic [30:0] cut,
                                                logic [31:0] res);
    logic [31:0] a0, a1, k0, fb;
    logic signed [63:0] loop;
    if (pos_in_block == 0) begin
      a0 = (last_coeff < Q24_ONE) ? last_coeff : Q24_ONE;
      a1 = ({1'b0, cut} < Q24_ONE) ? {1'b0, cut} : Q24_ONE;
      k0 = last_gain;
      loop = $signed({32'd0, a0}) * $signed({{32{k0[31]}}, k0});
      coeff_inc = $signed(a1 - a0) >>> LOG_BLOCK;
      gain_inc = $signed(res - k0) >>> LOG_BLOCK;
      if (a0 != 0 && loop >= $signed(LOOP_LIMIT)) k0 = ((32'h4000_0000) / a0) << 18;
      coeff_cur = a0;
      gain_cur = k0;
      last_coeff = {1'b0, cut};
      last_gain = res;
    end
    coeff_cur += coeff_inc;
    gain_cur += gain_inc;
    fb = q24_mul(gain_cur, stage_v[3]);
    stage_v[0] = stage_v[0] + q24_mul(sig - fb - stage_v[0], coeff_cur);
    stage_v[1] = stage_v[1] + q24_mul(stage_v[0] - stage_v[1], coeff_cur);
    stage_v[2] = stage_v[2] + q24_mul(stage_v[1] - stage_v[2], coeff_cur);
    stage_v[3] = stage_v[3] + q24_mul(stage_v[2] - stage_v[3], coeff_cur);
    pos_in_block = pos_in_block + 1'b1;
    return stage_v[3];
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // sink side: random stall bursts, checker
  initial begin
    int burst;
    out_stall = 0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        beats_out++;
        if (filtered_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: filtered=%h", filtered);
        end else begin
          logic [31:0] exp_v;
          exp_v = filtered_q.pop_front();
          if (filtered !== exp_v) begin
            errors++;
            if (errors <= 10)
              $display("mismatch beat %0d: expected %h actual %h", beats_out, exp_v, filtered);
          end
        end
      end
      if (burst > 0) begin
        burst--;
        out_stall <= (burst != 0);
      end else if (!calm && sink_idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall <= 1;
      end else begin
        out_stall <= 0;
      end
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WATCHDOG) begin
        $display("timeout");
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_sample(logic [31:0] s, logic [30:0] c, logic [31:0] r);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1;
    sample_in <= s;
    cutoff_coeff <= c;
    resonance <= r;
    do @(posedge clk); while (in_stall);
    filtered_q.push_back(ladder_predict(s, c, r));
    beats_in++;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [30:0] rand_cut();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($urandom_range(0, 32'h0100_0000));
      2: return 31'($urandom_range(32'h0080_0000, 32'h0100_0000));
      default: return 31'($urandom_range(0, 32'h0010_0000));
    endcase
  endfunction

  function automatic logic [31:0] rand_res();
    case ($urandom_range(0, 2))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0400_0000);
      default: return $urandom_range(32'h0100_0000, 32'h0800_0000);
    endcase
  endfunction

  // extremes of each field, zero coefficient, clamp, full scale gain
  task automatic test_directed();
    send_sample(32'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff);
    send_sample(32'h8000_0000, 31'h0, 32'h8000_0000);
    send_sample(32'h0, 31'h0100_0000, 32'h0);
    send_sample(32'hffff_ffff, 31'h0100_0001, 32'hffff_ffff);
    repeat (60) send_sample(32'h0100_0000, 31'h0, 32'h0);
    // block starts with a large loop gain to hit the division limit
    repeat (64) send_sample($urandom, 31'h0100_0000, 32'h0400_0000);
    repeat (64) send_sample($urandom, 31'h0080_0000, 32'h7fff_ffff);
    repeat (64) send_sample($urandom, 31'h7fff_ffff, 32'h8000_0000);
  endtask

  // random audio samples with random per-beat controls
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      logic [31:0] s;
      s = ($urandom_range(0, 3) == 0) ? $urandom : ($signed($urandom) >>> 6);
      send_sample(s, rand_cut(), rand_res());
    end
  endtask

  task automatic test_drain_pause();
    wait_drained();
    repeat (20) @(posedge clk);
    test_random(70);
  endtask

  task automatic test_no_idle();
    wait_drained();
    calm = 1;
    test_random(200);
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    sample_in = 0;
    cutoff_coeff = 0;
    resonance = 0;
    for (int i = 0; i < 4; i++) stage_v[i] = 0;
    coeff_cur = 0; gain_cur = 0; coeff_inc = 0; gain_inc = 0;
    last_coeff = 0; last_gain = 0; pos_in_block = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(624);
    test_drain_pause();
    test_random(800);
    test_no_idle();
    wait_drained();
    repeat (300) @(posedge clk);
    $display("sent %0d samples in %0d-sample blocks, checked %0d outputs", beats_in,
             1 << LOG_BLOCK, beats_out);
    $display("covered clamping, loop gain limit, wraparound and handshake stalls");
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
